// File: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// Sizes, request codes, slot record and result record.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] stamp;
    logic [WORD_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic              status;
    logic              expired;
    logic [WORD_W-1:0] expired_id;
    logic [WORD_W-1:0] expired_period;
    logic [WORD_W-1:0] expired_tag;
  } res_t;

endpackage

// File: src/ptt_req_if.sv
// ----------------------------------------------------------------------------
// ptt_req_if: request channel
// Valid/ready channel carrying one create, delete or tick item.
// ----------------------------------------------------------------------------
interface ptt_req_if import ptt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] timer_id;
  logic [WORD_W-1:0] period;
  logic [WORD_W-1:0] user_tag;

  modport source (output valid, output mode, output timer_id, output period,
                  output user_tag, input ready);
  modport sink   (input valid, input mode, input timer_id, input period,
                  input user_tag, output ready);
endinterface

// File: src/ptt_rsp_if.sv
// ----------------------------------------------------------------------------
// ptt_rsp_if: response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface ptt_rsp_if import ptt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              expired;
  logic [WORD_W-1:0] expired_id;
  logic [WORD_W-1:0] expired_period;
  logic [WORD_W-1:0] expired_tag;

  modport source (output valid, output status, output expired, output expired_id,
                  output expired_period, output expired_tag, input ready);
  modport sink   (input valid, input status, input expired, input expired_id,
                  input expired_period, input expired_tag, output ready);
endinterface

// File: src/ptt_slot_ram.sv
// ----------------------------------------------------------------------------
// ptt_slot_ram: slot record memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptt_slot_ram import ptt_pkg::*; (
  input  logic             clk,
  input  ram_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/ptt_scan_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_scan_ctrl: request sequencer
// Holds tick count and active flags, scans the slot memory one entry a
// cycle, writes back a create or tick hit slot and produces the result record.
// ----------------------------------------------------------------------------
module ptt_scan_ctrl import ptt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ptt_req_if.sink          req,
  output ram_wr_t          wr,
  output logic [IDX_W-1:0] rd_addr,
  input  slot_t            rd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] tick_count;
  logic [NUM_TIMERS-1:0] active;
  logic [CNT_W-1:0]  idx;
  logic              pend;
  logic [IDX_W-1:0]  pidx;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] id;
  logic [WORD_W-1:0] period;
  logic [WORD_W-1:0] tag;

  logic              hit;
  logic              scan_end;
  logic [WORD_W-1:0] elapsed;
  logic              accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_HOLD);
  assign rd_addr   = idx[IDX_W-1:0];
  assign elapsed   = tick_count - rd_data.stamp;
  assign scan_end  = !pend && (idx == CNT_W'(NUM_TIMERS));

  always_comb begin
    case (mode)
      MODE_CREATE: hit = pend && !active[pidx];
      MODE_DELETE: hit = pend && active[pidx] && (rd_data.id == id);
      MODE_TICK:   hit = pend && active[pidx] && (elapsed >= rd_data.period);
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    wr.en   = (state == S_SCAN) && hit && (mode != MODE_DELETE);
    wr.addr = pidx;
    if (mode == MODE_CREATE) begin
      wr.data = '{id: id, period: period, stamp: tick_count, tag: tag};
    end else begin
      wr.data = '{id: rd_data.id, period: rd_data.period, stamp: tick_count,
                  tag: rd_data.tag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      active     <= '0;
      pend       <= 1'b0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode   <= req.mode;
            id     <= req.timer_id;
            period <= req.period;
            tag    <= req.user_tag;
            idx    <= '0;
            pend   <= 1'b0;
            if (req.mode == MODE_TICK) begin
              tick_count <= tick_count + 1'b1;
            end
            if (req.mode inside {MODE_CREATE, MODE_DELETE, MODE_TICK}) begin
              state <= S_SCAN;
            end else begin
              res   <= '{status: 1'b1, default: '0};
              state <= S_HOLD;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            state <= S_HOLD;
            case (mode)
              MODE_CREATE: begin
                active[pidx] <= 1'b1;
                res          <= '0;
              end
              MODE_DELETE: begin
                active[pidx] <= 1'b0;
                res          <= '0;
              end
              default: begin
                res <= '{status: 1'b0, expired: 1'b1, expired_id: rd_data.id,
                         expired_period: rd_data.period,
                         expired_tag: rd_data.tag};
              end
            endcase
          end else if (scan_end) begin
            state <= S_HOLD;
            res   <= '{status: (mode != MODE_TICK), default: '0};
          end else if (idx < CNT_W'(NUM_TIMERS)) begin
            pend <= 1'b1;
            pidx <= idx[IDX_W-1:0];
            idx  <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        S_HOLD: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_TICK) |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick count did not advance by one");

  a_create_free: assert property (@(posedge clk) disable iff (rst)
    wr.en && (mode == MODE_CREATE) |-> !active[wr.addr])
    else $error("create wrote over an active slot");

  a_delete_frees: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && hit && (mode == MODE_DELETE) |=> !active[$past(pidx)])
    else $error("delete left its slot active");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_SCAN) && (32'(wr.addr) < NUM_TIMERS))
    else $error("slot write outside a scan or beyond the table");

endmodule

// File: src/ptt_out_reg.sv
// ----------------------------------------------------------------------------
// ptt_out_reg: result output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ptt_out_reg import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  output logic     res_ready,
  input  res_t     res,
  ptt_rsp_if.source rsp
);

  res_t held;

  assign res_ready          = !rsp.valid || rsp.ready;
  assign rsp.status         = held.status;
  assign rsp.expired        = held.expired;
  assign rsp.expired_id     = held.expired_id;
  assign rsp.expired_period = held.expired_period;
  assign rsp.expired_tag    = held.expired_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

endmodule

// File: src/periodic_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_core: table of periodic timers
// Requests arrive on req (mode 0 create, 1 delete, 2 tick) and each yields
// exactly one result item on rsp.
//
// Create stores id, period and tag in the lowest free slot, stamped with the
// current tick count; status 1 when the table is full. Delete frees the
// lowest active slot with a matching id; status 1 when none matches. Tick
// advances the 32-bit tick count and reports and restamps the lowest active
// slot whose elapsed count has reached its period. Mode 3 returns status 1.
//
// Slot records sit in a one-port-read, one-port-write memory; the sequencer
// reads one slot per cycle and stops the scan at the first hit or after the
// last slot; mode 3 goes straight to the result. One item is worked on at a
// time: req.ready is high only between items, while the sequencer is idle.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds rsp and, after one more result, the
// sequencer. Reset clears the tick count and all active flags at once.
// ----------------------------------------------------------------------------
module periodic_timer_table_core import ptt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ptt_req_if.sink   req,
  ptt_rsp_if.source rsp
);

  ram_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  ptt_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptt_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ptt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

endmodule
